// File: design/pc_sample_histogram_core_macros.svh
// Assertion macros shared by the histogram core.
`ifndef PC_SAMPLE_HISTOGRAM_CORE_MACROS_SVH
`define PC_SAMPLE_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PCSH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PCSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/pcsh_pkg.sv
// Package with the widths, codes, reset values and types of the histogram core.
package pcsh_pkg;

   localparam int ADDR_WIDTH       = 32;
   localparam int SCALE_WIDTH      = 17;
   localparam int LIMIT_WIDTH      = 13;
   localparam int READ_BIN_WIDTH   = 12;
   localparam int BIN_NUMBER_WIDTH = 16;
   localparam int BIN_COUNT_WIDTH  = 16;
   localparam int SCALE_SHIFT      = 16;
   localparam int PRODUCT_WIDTH    = ADDR_WIDTH + SCALE_WIDTH;

   localparam int DEF_NUM_BINS    = 4096;
   localparam int DEF_COUNT_WIDTH = 16;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [ADDR_WIDTH-1:0]  OFFSET_RESET = 32'd0;
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET  = 17'd65536;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET  = 13'd4096;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   typedef enum logic [1:0] {
      REG_ADDRESS_OFFSET = 2'd0,
      REG_ADDRESS_SCALE  = 2'd1,
      REG_BIN_LIMIT      = 2'd2
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_READ,
      ST_DONE
   } pcsh_state_type;

endpackage

// File: design/pcsh_if.sv
// Channel interfaces for the sample/read requests and the bin results.
interface pcsh_req_if import pcsh_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [ADDR_WIDTH-1:0]     sample_address;
   logic [READ_BIN_WIDTH-1:0] read_bin;

   modport source (output valid, output action, output sample_address, output read_bin,
                   input ready);
   modport sink   (input valid, input action, input sample_address, input read_bin,
                   output ready);
endinterface

interface pcsh_rsp_if import pcsh_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [BIN_NUMBER_WIDTH-1:0] bin_number;
   logic [BIN_COUNT_WIDTH-1:0]  bin_count;
   logic                        in_range;

   modport source (output valid, output bin_number, output bin_count, output in_range,
                   input ready);
   modport sink   (input valid, input bin_number, input bin_count, input in_range,
                   output ready);
endinterface

// File: design/pcsh_bin_ram.sv
// Single write port, single registered read port memory holding the bin counts.
module pcsh_bin_ram import pcsh_pkg::*; #(
   parameter int DEPTH  = DEF_NUM_BINS,
   parameter int WIDTH  = DEF_COUNT_WIDTH,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pc_sample_histogram_core.sv
// Program-counter sampling histogram core: top level with CSR port and bin update control.
//
// Usage. A request beat on req_chan either records a program-counter sample
// (action low) or reads one bin (action high). Each request gives exactly one
// response beat on rsp_chan carrying the bin number, the count and an in-range
// flag. A sample maps to bin ((pc - offset) * scale mod 2^32) >> 16; a bin at or
// above the smaller of the bin limit and the store size is dropped and flagged.
// The user must write the three registers through the APB-style csr_ port only
// while the core is idle; the core does not enforce this. pready is always high.
// Timing. One request is in flight at a time. It passes through the accept
// cycle (offset subtraction), the multiply state, a read of the count memory
// and the update state, which updates the count and loads the response
// register. A new request can be taken on the cycle after the response
// register is loaded, so the core takes no new request before it is through
// with the last one; the pace is set by the read-modify-write of the memory.
// Reset. After reset the core sweeps the count memory to zero, one entry per
// cycle, over all NUM_BINS entries; req_chan.ready stays low throughout the sweep.
// Stall. While the receiver holds rsp_chan.ready low, the response register
// keeps its beat; a later request waits in its update cycle until that slot frees.
`include "pc_sample_histogram_core_macros.svh"

module pc_sample_histogram_core import pcsh_pkg::*; #(
   parameter int NUM_BINS    = DEF_NUM_BINS,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   pcsh_req_if.sink                  req_chan,
   pcsh_rsp_if.source                rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int LIM_W = BIN_NUMBER_WIDTH + 1;
   localparam logic [LIM_W-1:0] NUM_BINS_L = LIM_W'(NUM_BINS);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_BINS - 1);

   // Configuration registers.
   logic [ADDR_WIDTH-1:0]  offset_ff;
   logic [SCALE_WIDTH-1:0] scale_ff;
   logic [LIMIT_WIDTH-1:0] limit_ff;
   csr_reg_type            csr_sel;
   logic                   csr_wr;

   // Sequencer and per-item working registers.
   pcsh_state_type            state_ff, state_in;
   logic [IDX_W-1:0]          clr_idx_ff;
   logic                      action_ff;
   logic [READ_BIN_WIDTH-1:0] read_bin_ff;
   logic [ADDR_WIDTH-1:0]     rel_ff;
   logic [BIN_NUMBER_WIDTH-1:0] bin_ff, bin_in;
   logic                      hit_ff, hit_in;
   logic [PRODUCT_WIDTH-1:0]  product;
   logic [LIM_W-1:0]          limit_eff;

   // Response register.
   logic                        rsp_valid_ff;
   logic [BIN_NUMBER_WIDTH-1:0] rsp_bin_ff;
   logic [BIN_COUNT_WIDTH-1:0]  rsp_count_ff;
   logic                        rsp_hit_ff;
   logic                        rsp_load;
   logic                        rsp_free;

   // Memory port signals.
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;
   logic                   mem_re;
   logic [COUNT_WIDTH-1:0] mem_rdata;
   logic [COUNT_WIDTH-1:0] count_new;
   logic [31:0]            count_ext;

   logic req_accept;

   // ------------------------------------------------------------------
   // CSR port. Writes complete in the access phase; only the register's
   // low bits are kept.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         scale_ff  <= SCALE_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_ADDRESS_OFFSET: offset_ff <= csr_pwdata[ADDR_WIDTH-1:0];
            REG_ADDRESS_SCALE:  scale_ff  <= csr_pwdata[SCALE_WIDTH-1:0];
            REG_BIN_LIMIT:      limit_ff  <= csr_pwdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_ADDRESS_OFFSET: csr_prdata = CSR_DATA_WIDTH'(offset_ff);
         REG_ADDRESS_SCALE:  csr_prdata = CSR_DATA_WIDTH'(scale_ff);
         REG_BIN_LIMIT:      csr_prdata = CSR_DATA_WIDTH'(limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Bin mapping. The limit in force is the smaller of the register and
   // the store size, so no bin outside the store is ever touched.
   // ------------------------------------------------------------------
   assign limit_eff = (LIM_W'(limit_ff) < NUM_BINS_L) ? LIM_W'(limit_ff) : NUM_BINS_L;
   assign product   = PRODUCT_WIDTH'(rel_ff) * PRODUCT_WIDTH'(scale_ff);

   always_comb begin
      if (action_ff == ACT_READ) begin
         bin_in = BIN_NUMBER_WIDTH'(read_bin_ff);
      end else begin
         bin_in = product[SCALE_SHIFT +: BIN_NUMBER_WIDTH];
      end
      hit_in = LIM_W'(bin_in) < limit_eff;
   end

   // ------------------------------------------------------------------
   // Sequencer: clearing sweep after reset, then accept, multiply, read
   // and update for each beat.
   // ------------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign count_new = (action_ff == ACT_SAMPLE) ? mem_rdata + COUNT_WIDTH'(1) : mem_rdata;
   assign count_ext = hit_ff ? 32'(count_new) : 32'd0;

   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      mem_waddr = bin_ff[IDX_W-1:0];
      mem_wdata = count_new;
      mem_re    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = '0;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            // Only bins below the limit in force are read; others report zero.
            mem_re   = hit_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               mem_we   = hit_ff && (action_ff == ACT_SAMPLE);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff   <= req_chan.action;
         read_bin_ff <= req_chan.read_bin;
         rel_ff      <= req_chan.sample_address - offset_ff;
      end
      if (state_ff == ST_MUL) begin
         bin_ff <= bin_in;
         hit_ff <= hit_in;
      end
   end

   pcsh_bin_ram #(
      .DEPTH  (NUM_BINS),
      .WIDTH  (COUNT_WIDTH),
      .ADDR_W (IDX_W)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (bin_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   // ------------------------------------------------------------------
   // Response register: holds its beat while the receiver stalls.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bin_ff   <= bin_ff;
         rsp_count_ff <= count_ext[BIN_COUNT_WIDTH-1:0];
         rsp_hit_ff   <= hit_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.bin_number = rsp_bin_ff;
   assign rsp_chan.bin_count  = rsp_count_ff;
   assign rsp_chan.in_range   = rsp_hit_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `PCSH_ASSERT_NOW(a_clear_blocks_req, clock, reset, (state_ff == ST_CLEAR),
      !req_chan.ready, "request taken during the clearing sweep")
   `PCSH_ASSERT_NEXT(a_accept_starts_mul, clock, reset, req_accept,
      (state_ff == ST_MUL), "accepted beat did not enter the multiply cycle")
   `PCSH_ASSERT_NOW(a_write_only_on_hit, clock, reset, (mem_we && (state_ff != ST_CLEAR)),
      (hit_ff && (action_ff == ACT_SAMPLE) && rsp_load), "count written without a counted sample")

endmodule

// File: sim/pc_sample_histogram_core_test.sv
// Self-checking testbench for the program-counter sampling histogram core.
`timescale 1ns / 100ps

module pc_sample_histogram_core_test;
   import pcsh_pkg::*;

   // The run is stopped as a failure if it goes on beyond this many cycles. The
   // slowest correct run (the clearing sweep plus the paced random part with
   // every wait drawn at its longest) stays well below a fifth of it.
   localparam int unsigned CYCLE_LIMIT = 400_000;

   // One beat on the request channel and one beat on the response channel.
   typedef struct packed {
      logic                      action;
      logic [ADDR_WIDTH-1:0]     sample_address;
      logic [READ_BIN_WIDTH-1:0] read_bin;
   } bin_request_type;

   typedef struct packed {
      logic [BIN_NUMBER_WIDTH-1:0] bin_number;
      logic [BIN_COUNT_WIDTH-1:0]  bin_count;
      logic                        in_range;
   } bin_result_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   pcsh_req_if req_bus ();
   pcsh_rsp_if rsp_bus ();

   pc_sample_histogram_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Our own copy of the histogram and of the three registers. It is updated as
   // each request beat is accepted, so it always runs exactly in step with the
   // order in which the core sees the requests.
   logic [DEF_COUNT_WIDTH-1:0] model_bins [DEF_NUM_BINS];
   logic [ADDR_WIDTH-1:0]      model_offset;
   logic [SCALE_WIDTH-1:0]     model_scale;
   logic [LIMIT_WIDTH-1:0]     model_limit;

   bin_request_type pending_requests[$];
   bin_result_type  expected_bins[$];

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Number of bins that can actually be hit: the limit register may name more
   // bins than the store holds, and then the store size wins.
   function automatic int unsigned usable_bins();
      return (model_limit > DEF_NUM_BINS) ? DEF_NUM_BINS : model_limit;
   endfunction

   // Works out the response to one request and applies a sample to our copy of
   // the histogram. The bin is bits 31:16 of the 32-bit wrapped product of the
   // relative address and the scale; counts wrap at their own width.
   function automatic bin_result_type histogram_step(input bin_request_type req);
      logic [ADDR_WIDTH-1:0]    rel;
      logic [PRODUCT_WIDTH-1:0] product;
      logic [31:0]              bin;
      bin_result_type           res;
      res = '0;
      if (req.action == ACT_SAMPLE) begin
         rel     = req.sample_address - model_offset;
         product = rel * model_scale;
         bin     = {16'd0, product[31:16]};
      end else begin
         bin = {20'd0, req.read_bin};
      end
      res.bin_number = bin[BIN_NUMBER_WIDTH-1:0];
      if (bin < usable_bins()) begin
         if (req.action == ACT_SAMPLE) begin
            model_bins[bin] = model_bins[bin] + 1'b1;
         end
         res.bin_count = model_bins[bin][BIN_COUNT_WIDTH-1:0];
         res.in_range  = 1'b1;
      end
      return res;
   endfunction

   // Cycles that one side waits before its next beat, drawn uniformly at random,
   // except in the stretches where that side runs flat out and does not wait.
   function automatic int draw_wait(input bit eager);
      return eager ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic bin_request_type sample_at(input logic [ADDR_WIDTH-1:0] pc);
      bin_request_type req;
      req.action         = ACT_SAMPLE;
      req.sample_address = pc;
      req.read_bin       = READ_BIN_WIDTH'($urandom());
      return req;
   endfunction

   function automatic bin_request_type read_of(input logic [READ_BIN_WIDTH-1:0] bin);
      bin_request_type req;
      req.action         = ACT_READ;
      req.sample_address = $urandom();
      req.read_bin       = bin;
      return req;
   endfunction

   // A random request for the current register setting. Most samples are aimed
   // at bins around the usable range (just past its top too), so that counts
   // build up and the limit is crossed; the rest are reads and stray addresses.
   function automatic bin_request_type random_request();
      bin_request_type  req;
      int unsigned      pick;
      int unsigned      target;
      longint unsigned  rel;
      req  = sample_at($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         req.action = ACT_READ;
         if (pick < 18) begin
            req.read_bin = READ_BIN_WIDTH'($urandom_range(0, usable_bins()));
         end
      end else if (pick >= 35 && model_scale != 0) begin
         target = $urandom_range(0, usable_bins() + 4);
         rel    = ((longint'(target) << SCALE_SHIFT) + $urandom_range(0, 65535)) / model_scale;
         req.sample_address = model_offset + rel[ADDR_WIDTH-1:0];
      end
      return req;
   endfunction

   task automatic push_request(input bin_request_type req);
      pending_requests.push_back(req);
      queued_count++;
   endtask

   // Waits until every queued request has been taken and has been answered.
   // Sampling on the falling edge keeps this clear of the clocked processes.
   task automatic wait_drained();
      while (accepted_count != queued_count || expected_bins.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // One write on the register port: a setup cycle, then an access cycle. The
   // register takes the value at the edge that ends the access cycle, and our
   // copy follows, keeping only the bits that the register holds.
   task automatic write_register(input csr_reg_type which,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (which)
         REG_ADDRESS_OFFSET: model_offset = value[ADDR_WIDTH-1:0];
         REG_ADDRESS_SCALE:  model_scale  = value[SCALE_WIDTH-1:0];
         REG_BIN_LIMIT:      model_limit  = value[LIMIT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Request driver. It offers the next pending request once its drawn wait has
   // run out, holds the beat until the core takes it, and predicts the response
   // at the very edge where the beat is accepted.
   bin_request_type offered;
   int              send_gap = 0;
   bit              sender_eager = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid          <= 1'b0;
         req_bus.action         <= ACT_SAMPLE;
         req_bus.sample_address <= '0;
         req_bus.read_bin       <= '0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_bins.push_back(histogram_step(offered));
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               offered = pending_requests.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.action         <= offered.action;
               req_bus.sample_address <= offered.sample_address;
               req_bus.read_bin       <= offered.read_bin;
               send_gap = draw_wait(sender_eager);
               if ($urandom_range(0, 39) == 0) begin
                  sender_eager = !sender_eager;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each beat is checked against the oldest prediction.
   // After a beat the receiver draws how long to keep ready low; every few
   // hundred beats it instead holds off for a long stretch, so that the core's
   // response slot stays full and the request channel backs up behind it.
   bin_result_type got;
   bin_result_type want;
   int             stall_left = 0;
   int             beats_since_hold = 0;
   bit             receiver_eager = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.bin_number = rsp_bus.bin_number;
            got.bin_count  = rsp_bus.bin_count;
            got.in_range   = rsp_bus.in_range;
            if (expected_bins.size() == 0) begin
               $display("%0t: response beat with nothing expected: bin %0d count %0d in_range %0b",
                        $time, got.bin_number, got.bin_count, got.in_range);
               error_count++;
            end else begin
               want = expected_bins.pop_front();
               if (got.bin_number !== want.bin_number || got.bin_count !== want.bin_count ||
                   got.in_range !== want.in_range) begin
                  $display("%0t: mismatch: expected bin %0d count %0d in_range %0b, got bin %0d count %0d in_range %0b",
                           $time, want.bin_number, want.bin_count, want.in_range,
                           got.bin_number, got.bin_count, got.in_range);
                  error_count++;
               end
            end
            beats_since_hold++;
            if (beats_since_hold >= 400) begin
               beats_since_hold = 0;
               stall_left = 300;
            end else begin
               stall_left = draw_wait(receiver_eager);
            end
            if ($urandom_range(0, 39) == 0) begin
               receiver_eager = !receiver_eager;
            end
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // Watchdog: a hung handshake must not leave the run going for ever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles", $time, cycle_count);
         $display("[pc_sample_histogram_core] ERROR");
         $finish;
      end
   end

   // Stimulus. Every phase is run to completion before the registers change, so
   // that the core is idle whenever a register is written.
   initial begin
      int unsigned                  idx;
      int unsigned                  phase;
      logic [ADDR_WIDTH-1:0]        new_offset;
      logic [SCALE_WIDTH-1:0]       new_scale;
      logic [LIMIT_WIDTH-1:0]       new_limit;

      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      for (idx = 0; idx < DEF_NUM_BINS; idx++) begin
         model_bins[idx] = '0;
      end
      model_offset = OFFSET_RESET;
      model_scale  = SCALE_RESET;
      model_limit  = LIMIT_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Settings straight out of reset: one bin per address, whole store in use.
      // The lowest and highest bins are counted, the first bin past the store
      // and the all-ones address are dropped, and reads see the counts.
      push_request(sample_at(32'h0000_0000));
      push_request(sample_at(32'h0000_0000));
      push_request(sample_at(32'h0000_0FFF));
      push_request(sample_at(32'h0000_1000));
      push_request(sample_at(32'hFFFF_FFFF));
      push_request(read_of(12'd0));
      push_request(read_of(12'hFFF));
      push_request(read_of(12'd1));
      wait_drained();

      // Offset near the top of the address space, the largest scale (nearly two
      // bins per address) and a limit well beyond the store, so the store size
      // decides. A relative address that wraps gives a huge bin that is dropped.
      write_register(REG_ADDRESS_OFFSET, 32'hFFFF_F000);
      write_register(REG_ADDRESS_SCALE, 32'd131071);
      write_register(REG_BIN_LIMIT, 32'd8191);
      push_request(sample_at(32'hFFFF_F000));
      push_request(sample_at(32'hFFFF_F001));
      push_request(sample_at(32'h0000_0FFF));
      push_request(sample_at(32'h0000_0034));
      push_request(sample_at(32'hFFFF_EFFF));
      push_request(read_of(12'hFFF));
      push_request(read_of(12'd0));
      wait_drained();

      // Register values with junk above the register's width: the scale ends up
      // as zero, so every sample falls in bin 0, and the limit ends up as one.
      write_register(REG_ADDRESS_OFFSET, 32'h1234_5678);
      write_register(REG_ADDRESS_SCALE, 32'hFFFE_0000);
      write_register(REG_BIN_LIMIT, 32'hFFFF_E001);
      push_request(sample_at($urandom()));
      push_request(sample_at($urandom()));
      push_request(read_of(12'd0));
      push_request(read_of(12'd1));
      wait_drained();

      // A limit of zero: nothing is counted and nothing can be read.
      write_register(REG_BIN_LIMIT, 32'd0);
      push_request(sample_at($urandom()));
      push_request(read_of(12'd0));
      wait_drained();

      // Random phases, each with a fresh register setting that often sits at an
      // extreme. Halfway through each phase the sender stops and waits for every
      // response before it carries on.
      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 3))
            0:       new_offset = '0;
            1:       new_offset = '1;
            default: new_offset = $urandom();
         endcase
         case ($urandom_range(0, 5))
            0:       new_scale = SCALE_RESET;
            1:       new_scale = '0;
            2:       new_scale = '1;
            3:       new_scale = SCALE_WIDTH'($urandom_range(1, 4096));
            default: new_scale = SCALE_WIDTH'($urandom_range(1, 131071));
         endcase
         case ($urandom_range(0, 6))
            0:       new_limit = '0;
            1:       new_limit = 13'd1;
            2:       new_limit = LIMIT_RESET;
            3:       new_limit = '1;
            4:       new_limit = 13'd4095;
            default: new_limit = LIMIT_WIDTH'($urandom_range(1, 8191));
         endcase
         write_register(REG_ADDRESS_OFFSET, new_offset);
         write_register(REG_ADDRESS_SCALE, {15'($urandom_range(0, 32767)), new_scale});
         write_register(REG_BIN_LIMIT, {19'($urandom_range(0, 524287)), new_limit});
         for (idx = 0; idx < 250; idx++) begin
            push_request(random_request());
            if (idx == 124) begin
               wait_drained();
            end
         end
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("[pc_sample_histogram_core] OK");
      end else begin
         $display("[pc_sample_histogram_core] ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/pcsh_pkg.sv
design/pcsh_if.sv
design/pcsh_bin_ram.sv
design/pc_sample_histogram_core.sv
sim/pc_sample_histogram_core_test.sv
